[design/bdkr_pkg.sv]
// Shared types and codes for the button debounce and key repeat block.
package bdkr_pkg;

   localparam int BTN_W      = 5;
   localparam int CMD_W      = 2;
   localparam int DEB_W      = 8;
   localparam int RPT_W      = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_IDX_W  = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REPEAT = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Repeat phase codes
   localparam logic [1:0] PH_IDLE     = 2'd0;
   localparam logic [1:0] PH_DELAY    = 2'd1;
   localparam logic [1:0] PH_INTERVAL = 2'd2;
   localparam logic [1:0] PH_DONE     = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL = 2'd2;

   // Reset values of the registers
   localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd20;
   localparam logic [RPT_W-1:0] DELAY_RST    = 16'd500;
   localparam logic [RPT_W-1:0] INTERVAL_RST = 16'd100;

   typedef struct packed {
      logic [DEB_W-1:0] debounce_ms;
      logic [RPT_W-1:0] repeat_delay_ms;
      logic [RPT_W-1:0] repeat_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic [BTN_W-1:0] stable_buttons;
      logic [BTN_W-1:0] repeat_buttons;
   } result_type;

endpackage

[design/bdkr_engine.sv]
// Debounce lockout and auto-repeat state with its one-step update.
module bdkr_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [bdkr_pkg::CMD_W-1:0]  cmd,
   input  logic [bdkr_pkg::BTN_W-1:0]  raw_buttons,
   input  bdkr_pkg::cfg_type           cfg,
   output bdkr_pkg::result_type        result
);
   import bdkr_pkg::*;

   logic [BTN_W-1:0] held_ff, held_in;
   logic             lock_active_ff, lock_active_in;
   logic [DEB_W-1:0] lock_count_ff, lock_count_in;
   logic [1:0]       phase_ff, phase_in;
   logic [RPT_W-1:0] count_ff, count_in;

   logic             change;
   logic [BTN_W-1:0] now_buttons;
   logic [1:0]       tick_phase;
   logic [RPT_W-1:0] tick_count;

   // Sample: take the raw vector only outside a lockout
   assign change      = !lock_active_ff && (raw_buttons != held_ff);
   assign now_buttons = change ? raw_buttons : held_ff;

   always_comb begin
      // tick: reload a pending counter, then count down
      tick_phase = phase_ff;
      tick_count = count_ff;
      if (phase_ff == PH_INTERVAL) begin
         tick_phase = PH_IDLE;
         tick_count = cfg.repeat_interval_ms;
      end else if (phase_ff == PH_DELAY) begin
         tick_phase = PH_IDLE;
         tick_count = cfg.repeat_delay_ms;
      end
      if (tick_count != '0) begin
         tick_count = tick_count - 1'b1;
         if (tick_count == '0) begin
            tick_phase = PH_DONE;
         end
      end
   end

   always_comb begin
      held_in        = held_ff;
      lock_active_in = lock_active_ff;
      lock_count_in  = lock_count_ff;
      phase_in       = phase_ff;
      count_in       = count_ff;
      result.stable_buttons = now_buttons;
      result.repeat_buttons = '0;
      if (fire) begin
         case (cmd)
            CMD_TICK: begin
               if (lock_active_ff) begin
                  if (lock_count_ff != '0) begin
                     lock_count_in = lock_count_ff - 1'b1;
                  end else begin
                     lock_active_in = 1'b0;
                     lock_count_in  = cfg.debounce_ms;
                  end
               end
               phase_in = tick_phase;
               count_in = tick_count;
            end
            CMD_SAMPLE, CMD_REPEAT: begin
               if (change) begin
                  lock_active_in = 1'b1;
                  held_in        = raw_buttons;
               end
               if (cmd == CMD_REPEAT && now_buttons != '0) begin
                  if (held_ff == '0) begin
                     phase_in = PH_DELAY;
                     result.repeat_buttons = now_buttons;
                  end else if (phase_ff == PH_DONE) begin
                     phase_in = PH_INTERVAL;
                     result.repeat_buttons = now_buttons;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff        <= '0;
         lock_active_ff <= 1'b0;
         lock_count_ff  <= '0;
         phase_ff       <= PH_IDLE;
         count_ff       <= '0;
      end else begin
         held_ff        <= held_in;
         lock_active_ff <= lock_active_in;
         lock_count_ff  <= lock_count_in;
         phase_ff       <= phase_in;
         count_ff       <= count_in;
      end
   end

   a_lock_reload: assert property (@(posedge clock) disable iff (reset)
      (lock_active_ff && !lock_active_in) |=> (lock_count_ff == $past(cfg.debounce_ms)))
      else $error("lockout end did not reload the counter");

   a_done_count_zero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> (count_ff == '0))
      else $error("repeat finished with a running counter");

   a_held_only_in_sample: assert property (@(posedge clock) disable iff (reset)
      (held_in != held_ff) |-> (fire && change && (cmd == CMD_SAMPLE || cmd == CMD_REPEAT)))
      else $error("held vector changed outside a sample");

endmodule

[design/button_debounce_key_repeat.sv]
// Top level: five-button debouncer with auto-repeat, beat handshakes and register port.
// Flow: a sample beat accepted into the input register moves on to the result register
//   once the result register is free, and is presented from there as a result beat.
// Throughput: one beat per cycle; the input register advances whenever the result
//   register is empty or being drained, and tick beats never wait for it.
// Reset (synchronous, active high): clears held vector, lockout, repeat phase and
//   counter, empties both registers and restores the register defaults (20, 500, 100).
module button_debounce_key_repeat (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bdkr_pkg::CMD_W-1:0]       req_cmd,
   input  logic [bdkr_pkg::BTN_W-1:0]       req_raw_buttons,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [bdkr_pkg::BTN_W-1:0]       rsp_stable_buttons,
   output logic [bdkr_pkg::BTN_W-1:0]       rsp_repeat_buttons,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bdkr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bdkr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bdkr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import bdkr_pkg::*;

   // Configuration registers
   cfg_type cfg_ff, cfg_in;
   logic    csr_write;
   logic [CSR_IDX_W-1:0] csr_idx;

   // Input register
   logic             s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0] s1_cmd_ff;
   logic [BTN_W-1:0] s1_raw_ff;
   logic             s1_has_rsp;
   logic             s1_fire;

   // Result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [BTN_W-1:0] rsp_stable_ff;
   logic [BTN_W-1:0] rsp_repeat_ff;
   logic             out_free;

   result_type       eng_result;

   // ---------------------------------------------------------------------------
   // Register port: write on the access phase, read back combinationally
   // ---------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_idx)
            REG_DEBOUNCE: cfg_in.debounce_ms        = csr_pwdata[DEB_W-1:0];
            REG_DELAY:    cfg_in.repeat_delay_ms    = csr_pwdata[RPT_W-1:0];
            REG_INTERVAL: cfg_in.repeat_interval_ms = csr_pwdata[RPT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DEBOUNCE: csr_prdata = {{(CSR_DATA_W-DEB_W){1'b0}}, cfg_ff.debounce_ms};
         REG_DELAY:    csr_prdata = {{(CSR_DATA_W-RPT_W){1'b0}}, cfg_ff.repeat_delay_ms};
         REG_INTERVAL: csr_prdata = {{(CSR_DATA_W-RPT_W){1'b0}}, cfg_ff.repeat_interval_ms};
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Beat flow: hold a sample in the input register until the result register
   // frees up; drop ticks and the unused command straight through.
   // ---------------------------------------------------------------------------
   assign s1_has_rsp = (s1_cmd_ff == CMD_SAMPLE) || (s1_cmd_ff == CMD_REPEAT);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_fire    = s1_valid_ff && (!s1_has_rsp || out_free);
   assign req_ready  = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_has_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Advance the state by one command as the beat leaves the input register
   bdkr_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .fire        (s1_fire),
      .cmd         (s1_cmd_ff),
      .raw_buttons (s1_raw_ff),
      .cfg         (cfg_ff),
      .result      (eng_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms        <= DEBOUNCE_RST;
         cfg_ff.repeat_delay_ms    <= DELAY_RST;
         cfg_ff.repeat_interval_ms <= INTERVAL_RST;
         s1_valid_ff               <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: capture on acceptance or on load, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff <= req_cmd;
         s1_raw_ff <= req_raw_buttons;
      end
      if (s1_fire && s1_has_rsp) begin
         rsp_stable_ff <= eng_result.stable_buttons;
         rsp_repeat_ff <= eng_result.repeat_buttons;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_stable_buttons = rsp_stable_ff;
   assign rsp_repeat_buttons = rsp_repeat_ff;

   a_tick_no_result: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !s1_has_rsp && rsp_valid_ff && rsp_ready) |=> !rsp_valid_ff)
      else $error("tick beat produced a result");

   a_repeat_is_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_repeat_ff != '0) |-> (rsp_repeat_ff == rsp_stable_ff))
      else $error("reported keys differ from debounced vector");

   a_sample_waits: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_has_rsp && rsp_valid_ff && !rsp_ready) |=> s1_valid_ff)
      else $error("sample beat left while result register was full");

endmodule
